@@ rtl/slx_pkg.sv @@
// Package for the script lexer: transaction types, token kinds, error codes
// and the keyword table. No dependencies.
package slx_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       at_end;
    } item_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [30:0] number;
        logic [4:0]  fraction_digits;
        logic [7:0]  text_char;
        logic        char_valid;
        logic [2:0]  error_code;
        logic        token_last;
    } token_t;

    typedef struct packed {
        logic       is_space;
        logic       is_digit;
        logic       is_alpha;
        logic       is_quote;
        logic       is_backslash;
        logic       is_point;
        logic [4:0] punct_kind;
        logic [7:0] esc_char;
    } char_class_t;

    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_STRING = 5'd13;
    localparam logic [4:0] KIND_INT    = 5'd14;
    localparam logic [4:0] KIND_FLOAT  = 5'd15;
    localparam logic [4:0] KIND_NAME   = 5'd16;
    localparam logic [4:0] KIND_KW0    = 5'd17;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_POINT    = 3'd2;
    localparam logic [2:0] ERR_OPEN_STR = 3'd3;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd4;
    localparam logic [2:0] ERR_LONG     = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW = 3'd6;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    localparam int NUM_KW = 5;
    localparam logic [NUM_KW-1:0][4:0][7:0] KW_TEXT = '{
        {8'h00, 8'h00, 8'h4E, 8'h55, 8'h46},
        {8'h45, 8'h4C, 8'h49, 8'h48, 8'h57},
        {8'h00, 8'h00, 8'h52, 8'h4F, 8'h46},
        {8'h00, 8'h45, 8'h53, 8'h4C, 8'h45},
        {8'h00, 8'h00, 8'h00, 8'h46, 8'h49}
    };
    localparam logic [NUM_KW-1:0][2:0] KW_LEN = '{3'd3, 3'd5, 3'd3, 3'd4, 3'd2};

endpackage

@@ rtl/slx_class.sv @@
// Character classifier for the script lexer: character classes, punctuation
// kind and escape decoding. Depends on slx_pkg.
module slx_class
    import slx_pkg::*;
(
    input  logic [7:0]  character,
    output char_class_t cls
);

    always_comb
    begin
        cls.is_space     = (character == 8'h20) || (character >= 8'h09 && character <= 8'h0D);
        cls.is_digit     = (character >= 8'h30) && (character <= 8'h39);
        cls.is_alpha     = (character >= 8'h41 && character <= 8'h5A) ||
                           (character >= 8'h61 && character <= 8'h7A);
        cls.is_quote     = (character == 8'h22);
        cls.is_backslash = (character == 8'h5C);
        cls.is_point     = (character == 8'h2E);
        unique case (character)
            8'h28:   cls.punct_kind = 5'd1;
            8'h29:   cls.punct_kind = 5'd2;
            8'h2C:   cls.punct_kind = 5'd3;
            8'h3B:   cls.punct_kind = 5'd4;
            8'h7B:   cls.punct_kind = 5'd5;
            8'h7D:   cls.punct_kind = 5'd6;
            8'h3D:   cls.punct_kind = 5'd7;
            8'h2B:   cls.punct_kind = 5'd8;
            8'h2D:   cls.punct_kind = 5'd9;
            8'h2A:   cls.punct_kind = 5'd10;
            8'h2F:   cls.punct_kind = 5'd11;
            8'h25:   cls.punct_kind = 5'd12;
            default: cls.punct_kind = 5'd0;
        endcase
        unique case (character)
            8'h74:   cls.esc_char = 8'h09;
            8'h72:   cls.esc_char = 8'h0D;
            8'h6E:   cls.esc_char = 8'h0A;
            8'h22:   cls.esc_char = 8'h22;
            8'h5C:   cls.esc_char = 8'h5C;
            default: cls.esc_char = 8'h00;
        endcase
    end

endmodule

@@ rtl/script_lexer.sv @@
// Top level of the script lexer: control sequencer, token state and the
// name buffer memory. Depends on slx_pkg and slx_class.
//
//  Channel  Direction  Payload  Handshake
//  item     in         item_t   item_valid / item_stall
//  token    out        token_t  token_valid / token_stall
//
// A character inside a string or a number passes the input and dispatch
// steps. A character read in idle, or one that ends a number or a name,
// also passes the start step. The dispatch and start steps wait while the
// output register is held. Flushing a plain name reads each character from
// the buffer memory and then loads it into the output register.
// Reset clears all control state; the name buffer is not cleared.
// item_stall is high whenever the sequencer is not waiting for a character.
module script_lexer
    import slx_pkg::*;
#(
    parameter int MAX_NAME = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output logic   token_valid,
    input  logic   token_stall,
    output token_t token
);

    localparam int AW = $clog2(MAX_NAME);
    localparam int LW = $clog2(MAX_NAME + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_NAME);

    localparam logic [2:0] S_IN       = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_TAIL     = 3'd2;
    localparam logic [2:0] S_NAME_RD  = 3'd3;
    localparam logic [2:0] S_NAME_OUT = 3'd4;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_STRING = 3'd1;
    localparam logic [2:0] M_ESCAPE = 3'd2;
    localparam logic [2:0] M_NUMBER = 3'd3;
    localparam logic [2:0] M_NAME   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        mode_reg, mode_next;
    logic [30:0]       acc_reg, acc_next;
    logic              point_reg, point_next;
    logic [4:0]        frac_reg, frac_next;
    logic              ovf_reg, ovf_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [NUM_KW-1:0] kw_reg, kw_next;
    logic [7:0]        ch_reg, ch_next;
    logic              end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    token_t            out_reg, out_next;

    logic [7:0]        name_mem [MAX_NAME];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;

    char_class_t       cls;
    logic              can_put;
    logic              put;
    token_t            res;
    logic [34:0]       prod;
    logic [NUM_KW-1:0] kw_hit;
    logic [4:0]        kw_kind;

    slx_class u_class
    (
        .character (ch_reg),
        .cls       (cls)
    );

    assign item_stall  = (state_reg != S_IN);
    assign token_valid = out_valid_reg;
    assign token       = out_reg;
    assign can_put     = !out_valid_reg || !token_stall;
    assign prod        = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                         35'(ch_reg - 8'h30);

    always_comb
    begin
        kw_kind = KIND_EOF;
        for (int k = 0; k < NUM_KW; k++)
        begin
            kw_hit[k] = kw_reg[k] && (len_reg == LW'(KW_LEN[k]));
        end
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (kw_hit[k])
            begin
                kw_kind = KIND_KW0 + 5'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        point_next = point_reg;
        frac_next  = frac_reg;
        ovf_next   = ovf_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        kw_next    = kw_reg;
        ch_next    = ch_reg;
        end_next   = end_reg;
        mem_we     = 1'b0;
        mem_waddr  = len_reg[AW-1:0];
        put        = 1'b0;
        res        = '0;
        res.token_last = 1'b1;

        unique case (state_reg)
            S_IN:
            begin
                if (item_valid)
                begin
                    ch_next    = item.character;
                    end_next   = item.at_end;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (can_put)
                begin
                    state_next = S_IN;
                    if (end_reg || (mode_reg == M_IDLE))
                    begin
                        state_next = S_TAIL;
                        unique case (mode_reg)
                            M_NUMBER:
                            begin
                                put = 1'b1;
                                res.kind = point_reg ? KIND_FLOAT : KIND_INT;
                                res.number = acc_reg;
                                res.fraction_digits = point_reg ? frac_reg : 5'd0;
                                res.error_code = ovf_reg ? ERR_OVERFLOW : ERR_NONE;
                            end
                            M_NAME:
                            begin
                                if (kw_kind != KIND_EOF)
                                begin
                                    put = 1'b1;
                                    res.kind = kw_kind;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = S_NAME_RD;
                                end
                            end
                            M_STRING, M_ESCAPE:
                            begin
                                put = 1'b1;
                                res.error_code = ERR_OPEN_STR;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (mode_reg != M_NAME || kw_kind != KIND_EOF)
                        begin
                            mode_next = M_IDLE;
                        end
                    end
                    else
                    begin
                        unique case (mode_reg)
                            M_STRING:
                            begin
                                if (cls.is_quote)
                                begin
                                    put = 1'b1;
                                    res.kind = KIND_STRING;
                                    mode_next = M_IDLE;
                                end
                                else if (cls.is_backslash)
                                begin
                                    mode_next = M_ESCAPE;
                                end
                                else
                                begin
                                    put = 1'b1;
                                    res.kind = KIND_STRING;
                                    res.text_char = ch_reg;
                                    res.char_valid = 1'b1;
                                    res.token_last = 1'b0;
                                end
                            end
                            M_ESCAPE:
                            begin
                                put = 1'b1;
                                if (cls.esc_char != 8'h00)
                                begin
                                    res.kind = KIND_STRING;
                                    res.text_char = cls.esc_char;
                                    res.char_valid = 1'b1;
                                    res.token_last = 1'b0;
                                    mode_next = M_STRING;
                                end
                                else
                                begin
                                    res.error_code = ERR_ESCAPE;
                                    mode_next = M_IDLE;
                                end
                            end
                            M_NUMBER:
                            begin
                                if (cls.is_digit)
                                begin
                                    if (prod > {4'b0, NUM_MAX})
                                    begin
                                        acc_next = NUM_MAX;
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        acc_next = prod[30:0];
                                    end
                                    if (point_reg && frac_reg != 5'd31)
                                    begin
                                        frac_next = frac_reg + 5'd1;
                                    end
                                end
                                else if (cls.is_point)
                                begin
                                    if (point_reg)
                                    begin
                                        put = 1'b1;
                                        res.error_code = ERR_POINT;
                                        mode_next = M_IDLE;
                                    end
                                    else
                                    begin
                                        point_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    put = 1'b1;
                                    res.kind = point_reg ? KIND_FLOAT : KIND_INT;
                                    res.number = acc_reg;
                                    res.fraction_digits = point_reg ? frac_reg : 5'd0;
                                    res.error_code = ovf_reg ? ERR_OVERFLOW : ERR_NONE;
                                    mode_next = M_IDLE;
                                    state_next = S_TAIL;
                                end
                            end
                            default:
                            begin
                                if (cls.is_alpha)
                                begin
                                    if (len_reg < MAX_LEN)
                                    begin
                                        mem_we = 1'b1;
                                        len_next = len_reg + LW'(1);
                                        for (int k = 0; k < NUM_KW; k++)
                                        begin
                                            kw_next[k] = kw_reg[k] &&
                                                (len_reg < LW'(KW_LEN[k])) &&
                                                (KW_TEXT[k][len_reg[2:0]] == ch_reg);
                                        end
                                    end
                                    else
                                    begin
                                        put = 1'b1;
                                        res.error_code = ERR_LONG;
                                        mode_next = M_IDLE;
                                    end
                                end
                                else if (kw_kind != KIND_EOF)
                                begin
                                    put = 1'b1;
                                    res.kind = kw_kind;
                                    mode_next = M_IDLE;
                                    state_next = S_TAIL;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = S_NAME_RD;
                                end
                            end
                        endcase
                        if (mode_next == M_IDLE)
                        begin
                            acc_next   = '0;
                            point_next = 1'b0;
                            frac_next  = '0;
                            ovf_next   = 1'b0;
                            if (state_next != S_NAME_RD)
                            begin
                                len_next = '0;
                            end
                        end
                    end
                end
            end
            S_NAME_RD:
            begin
                state_next = S_NAME_OUT;
            end
            S_NAME_OUT:
            begin
                if (can_put)
                begin
                    put = 1'b1;
                    res.kind = KIND_NAME;
                    res.text_char = rdata_reg;
                    res.char_valid = 1'b1;
                    res.token_last = (LW'(idx_reg) + LW'(1) == len_reg);
                    if (res.token_last)
                    begin
                        mode_next  = M_IDLE;
                        len_next   = '0;
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_NAME_RD;
                    end
                end
            end
            default:
            begin
                if (can_put)
                begin
                    state_next = S_IN;
                    acc_next   = '0;
                    point_next = 1'b0;
                    frac_next  = '0;
                    ovf_next   = 1'b0;
                    len_next   = '0;
                    mode_next  = M_IDLE;
                    if (end_reg)
                    begin
                        put = 1'b1;
                    end
                    else if (cls.is_space)
                    begin
                    end
                    else if (cls.punct_kind != 5'd0)
                    begin
                        put = 1'b1;
                        res.kind = cls.punct_kind;
                    end
                    else if (cls.is_quote)
                    begin
                        mode_next = M_STRING;
                    end
                    else if (cls.is_digit)
                    begin
                        mode_next = M_NUMBER;
                        acc_next  = 31'(ch_reg - 8'h30);
                    end
                    else if (cls.is_alpha)
                    begin
                        mode_next = M_NAME;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        len_next  = LW'(1);
                        for (int k = 0; k < NUM_KW; k++)
                        begin
                            kw_next[k] = (KW_TEXT[k][0] == ch_reg);
                        end
                    end
                    else
                    begin
                        put = 1'b1;
                        res.error_code = ERR_BAD_CHAR;
                    end
                end
            end
        endcase

        out_valid_next = out_valid_reg && token_stall;
        out_next       = out_reg;
        if (put)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            name_mem[mem_waddr] <= ch_reg;
        end
        rdata_reg <= name_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            mode_reg      <= M_IDLE;
            acc_reg       <= '0;
            point_reg     <= 1'b0;
            frac_reg      <= '0;
            ovf_reg       <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            kw_reg        <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            point_reg     <= point_next;
            frac_reg      <= frac_next;
            ovf_reg       <= ovf_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            kw_reg        <= kw_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        out_reg <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= MAX_LEN)
        else $error("Name length exceeds the buffer depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token.error_code != ERR_NONE && token.error_code != ERR_OVERFLOW)
        |-> (token.kind == KIND_EOF && token.token_last))
        else $error("Error transaction is not a final kind-zero result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token.char_valid)
        |-> (token.kind == KIND_STRING || token.kind == KIND_NAME))
        else $error("Character carried by a token kind without text.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NAME_OUT) |-> (LW'(idx_reg) < len_reg))
        else $error("Name flush reads beyond the stored length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_DISPATCH))
        else $error("Accepted character was not dispatched.");

endmodule
